FILE: hw/rtl/xtea_decipher_64_cycles_assert.svh
// Assertion macros for the XTEA decipher block.
`ifndef XTEA_DECIPHER_64_CYCLES_ASSERT_SVH
`define XTEA_DECIPHER_64_CYCLES_ASSERT_SVH

// Checked only while out of reset.
`define XTDC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("xtdc assertion failed");

// Checked on every edge, reset included.
`define XTDC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("xtdc assertion failed");

`endif

FILE: hw/rtl/xtdc_pkg.sv
// ----------------------------------------------------------------------------
// xtdc_pkg
// Types, constants and the round mix function for the XTEA decipher block.
// ----------------------------------------------------------------------------
package xtdc_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned KEY_WORDS = 4;
    localparam int unsigned KEY_IDX_W = 2;
    localparam int unsigned ROUNDS_DEF = 64;
    localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [KEY_IDX_W-1:0] t_key_idx;
    typedef t_word [KEY_WORDS-1:0] t_key_arr;

    typedef struct packed {
        t_word cipher_first;
        t_word cipher_second;
    } t_in_data;

    typedef struct packed {
        t_word plain_first;
        t_word plain_second;
    } t_out_data;

    // Block as it moves through the pipeline
    typedef struct packed {
        t_word first;
        t_word second;
    } t_blk;

    // Pipeline handshake between stages
    typedef struct packed {
        logic en;
        logic valid;
    } t_stg_ctl;

    function automatic t_word xtdc_mix(input t_word w);
        return ((w << 4) ^ (w >> 5)) + w;
    endfunction

endpackage

FILE: hw/rtl/xtdc_key_regs.sv
// ----------------------------------------------------------------------------
// xtdc_key_regs
// Four 32-bit key registers written through the configuration port.
// ----------------------------------------------------------------------------
module xtdc_key_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  xtdc_pkg::t_key_idx i_cfg_index,
    input  xtdc_pkg::t_word    i_cfg_data,
    output xtdc_pkg::t_key_arr o_key
);
    import xtdc_pkg::*;

    t_key_arr r_key;

    assign o_cfg_ready = 1'b1;
    assign o_key       = r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

endmodule

FILE: hw/rtl/xtdc_half_round.sv
// ----------------------------------------------------------------------------
// xtdc_half_round
// One registered half round: updates either the second or the first word.
// ----------------------------------------------------------------------------
module xtdc_half_round #(
    parameter logic [31:0] SUM        = 32'h0,
    parameter bit          UPD_SECOND = 1'b1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  xtdc_pkg::t_stg_ctl i_ctl,
    input  xtdc_pkg::t_blk     i_blk,
    input  xtdc_pkg::t_word    i_key,
    output logic               o_valid,
    output xtdc_pkg::t_blk     o_blk
);
    import xtdc_pkg::*;

    logic  r_valid;
    t_blk  r_blk;
    t_blk  n_blk;
    t_word sum_key;

    assign sum_key = SUM + i_key;

    always_comb begin
        n_blk = i_blk;
        if (UPD_SECOND) begin
            n_blk.second = i_blk.second - (xtdc_mix(i_blk.first) ^ sum_key);
        end else begin
            n_blk.first = i_blk.first - (xtdc_mix(i_blk.second) ^ sum_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_blk <= n_blk;
        end
    end

    assign o_valid = r_valid;
    assign o_blk   = r_blk;

endmodule

FILE: hw/rtl/xtea_decipher_64_cycles.sv
// A request passes through both half-round registers of every round before its result is valid.
// Throughput: one block per cycle while the result is not stalled; each round is two register stages, one per word.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all stage valid bits and the key words.
// ----------------------------------------------------------------------------
// xtea_decipher_64_cycles
// Fully pipelined XTEA block decipher with a 128-bit configurable key.
// ----------------------------------------------------------------------------
module xtea_decipher_64_cycles #(
    parameter int unsigned ROUNDS = xtdc_pkg::ROUNDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  xtdc_pkg::t_in_data  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output xtdc_pkg::t_out_data o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  xtdc_pkg::t_key_idx  i_cfg_index,
    input  xtdc_pkg::t_word     i_cfg_data
);
    import xtdc_pkg::*;

    localparam int unsigned NSTG = 2 * ROUNDS;

    t_key_arr key;
    logic     adv;
    logic     stg_valid [0:NSTG];
    t_blk     stg_blk   [0:NSTG];

    xtdc_key_regs u_keys (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_key       (key)
    );

    // Whole pipe moves unless the result at the end is held
    assign adv        = !(stg_valid[NSTG] && i_out_stall);
    assign o_in_stall = !adv;

    assign stg_valid[0]      = i_in_valid;
    assign stg_blk[0].first  = i_in_data.cipher_first;
    assign stg_blk[0].second = i_in_data.cipher_second;

    for (genvar r = 0; r < ROUNDS; r++) begin : g_round
        localparam logic [63:0] PROD   = 64'(DELTA) * 64'(ROUNDS - r);
        localparam logic [31:0] SUM_HI = PROD[31:0];
        localparam logic [31:0] SUM_LO = SUM_HI - DELTA;

        t_stg_ctl ctl_a;
        t_stg_ctl ctl_b;

        assign ctl_a = '{en: adv, valid: stg_valid[2*r]};
        assign ctl_b = '{en: adv, valid: stg_valid[2*r+1]};

        xtdc_half_round #(.SUM(SUM_HI), .UPD_SECOND(1'b1)) u_hr_second (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl_a),
            .i_blk   (stg_blk[2*r]),
            .i_key   (key[SUM_HI[12:11]]),
            .o_valid (stg_valid[2*r+1]),
            .o_blk   (stg_blk[2*r+1])
        );

        xtdc_half_round #(.SUM(SUM_LO), .UPD_SECOND(1'b0)) u_hr_first (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl_b),
            .i_blk   (stg_blk[2*r+1]),
            .i_key   (key[SUM_LO[1:0]]),
            .o_valid (stg_valid[2*r+2]),
            .o_blk   (stg_blk[2*r+2])
        );
    end

    assign o_out_valid             = stg_valid[NSTG];
    assign o_out_data.plain_first  = stg_blk[NSTG].first;
    assign o_out_data.plain_second = stg_blk[NSTG].second;

endmodule

FILE: hw/rtl/xtdc_checker.sv
// ----------------------------------------------------------------------------
// xtdc_checker
// Port-level checks for the XTEA decipher block, bound to the top level.
// ----------------------------------------------------------------------------
`include "xtea_decipher_64_cycles_assert.svh"

module xtdc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input xtdc_pkg::t_out_data o_out_data
);
    import xtdc_pkg::*;

    // No result right after a reset cycle
    `XTDC_ASSERT_ALWAYS(a_rst_no_result, i_clk, !i_rst_n |=> !o_out_valid)

    // Input backs up only when a result is held at the output
    `XTDC_ASSERT(a_stall_only_on_hold, i_clk, i_rst_n,
        o_in_stall == (o_out_valid && i_out_stall))

    // A held result stays put
    `XTDC_ASSERT(a_hold_result, i_clk, i_rst_n,
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))

endmodule

bind xtea_decipher_64_cycles xtdc_checker u_xtdc_checker (.*);
